// ===== design/lsc_pkg.sv =====
// Shared types and constants for the lidar scan cluster segmenter.
// No dependencies; imported by every module of the block.
`default_nettype none

package lsc_pkg;

  typedef logic signed [8:0] angle_t;
  typedef logic [15:0]       range_t;
  typedef logic [9:0]        count_t;

  localparam count_t COUNT_MAX = 10'd1023;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_GAP  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_POINTS = 3'd6;

  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    angle_t      angle_low;
    angle_t      angle_high;
    range_t      range_low;
    range_t      range_high;
    logic [8:0]  angle_gap;
    range_t      range_gap;
    count_t      min_points;
  } cfg_t;

  typedef struct packed {
    angle_t nearest_angle;
    range_t nearest_range;
    angle_t left_angle;
    range_t left_range;
    angle_t right_angle;
    range_t right_range;
    count_t count;
    logic   last;
  } report_t;

  // Reports raised by one point, packed in order from rep[0]
  typedef struct packed {
    logic [1:0]        num;
    report_t [1:0]     rep;
  } push_t;

endpackage

`default_nettype wire

// ===== design/lidar_scan_cluster_segmenter_top.sv =====
// Lidar scan cluster segmenter: one point in per cycle, one cluster report
// out per cycle. The configuration registers live here; the cluster logic
// is in lsc_cluster and the result queue in lsc_out_fifo.
//
// Each point is processed in the cycle it is transferred, and its reports
// (none, one or two) enter a four-entry queue at the same edge. A point can
// be transferred every cycle while the queue holds two or fewer reports, so
// the block sustains one point per cycle as long as the output side takes
// reports at least as fast as they are produced; the single output port of
// the queue sets the limit of one report per cycle. Register writes are
// always taken and must come only while no point is in flight.
`default_nettype none

module lidar_scan_cluster_segmenter_top
  import lsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire angle_t                angle_deg,
  input  wire range_t                range_mm,
  input  wire logic                  end_of_scan,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output angle_t                     nearest_angle_deg,
  output range_t                     nearest_range_mm,
  output angle_t                     left_angle_deg,
  output range_t                     left_range_mm,
  output angle_t                     right_angle_deg,
  output range_t                     right_range_mm,
  output count_t                     point_count,
  output logic                       last_of_run
);

  cfg_t    cfg;
  logic    fire;
  logic    has_room;
  push_t   push;
  report_t head;

  assign cfg_ready = 1'b1;
  assign in_ready  = has_room;
  assign fire      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_low  <= -9'sd60;
      cfg.angle_high <= 9'sd60;
      cfg.range_low  <= 16'd3000;
      cfg.range_high <= 16'd4000;
      cfg.angle_gap  <= 9'd2;
      cfg.range_gap  <= 16'd150;
      cfg.min_points <= 10'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ANGLE_LOW:  cfg.angle_low  <= cfg_data[8:0];
        REG_ANGLE_HIGH: cfg.angle_high <= cfg_data[8:0];
        REG_RANGE_LOW:  cfg.range_low  <= cfg_data;
        REG_RANGE_HIGH: cfg.range_high <= cfg_data;
        REG_ANGLE_GAP:  cfg.angle_gap  <= cfg_data[8:0];
        REG_RANGE_GAP:  cfg.range_gap  <= cfg_data;
        REG_MIN_POINTS: cfg.min_points <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  lsc_cluster u_cluster (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .angle_in (angle_deg),
    .range_in (range_mm),
    .eos      (end_of_scan),
    .cfg      (cfg),
    .push     (push)
  );

  lsc_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fire),
    .push     (push),
    .has_room (has_room),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (head)
  );

  assign nearest_angle_deg = head.nearest_angle;
  assign nearest_range_mm  = head.nearest_range;
  assign left_angle_deg    = head.left_angle;
  assign left_range_mm     = head.left_range;
  assign right_angle_deg   = head.right_angle;
  assign right_range_mm    = head.right_range;
  assign point_count       = head.count;
  assign last_of_run       = head.last;

endmodule

`default_nettype wire

// ===== design/lsc_cluster.sv =====
// Per-point gating, breakpoint test and cluster state update.
// Depends on lsc_pkg; produces up to two reports per accepted point.
`default_nettype none

module lsc_cluster
  import lsc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   fire,
  input  wire angle_t angle_in,
  input  wire range_t range_in,
  input  wire logic   eos,
  input  wire cfg_t   cfg,
  output push_t       push
);

  logic   cluster_open;
  angle_t prev_angle, first_angle, min_angle;
  range_t prev_range, first_range, min_range;
  count_t cluster_count;

  logic   cluster_open_next;
  angle_t prev_angle_next, first_angle_next, min_angle_next;
  range_t prev_range_next, first_range_next, min_range_next;
  count_t cluster_count_next;

  logic              kept;
  logic signed [9:0] da_s;
  logic [9:0]        da;
  range_t            dr;
  logic              brk;
  logic              v0, v1;
  report_t           r0, r1;
  logic              open_mid;

  always_comb begin
    kept = (angle_in >= cfg.angle_low) && (angle_in <= cfg.angle_high) &&
           (range_in > cfg.range_low) && (range_in < cfg.range_high);
    da_s = 10'(angle_in) - 10'(prev_angle);
    da   = da_s[9] ? 10'(-da_s) : 10'(da_s);
    dr   = (range_in > prev_range) ? range_in - prev_range : prev_range - range_in;
    brk  = cluster_open && kept &&
           ((da > {1'b0, cfg.angle_gap}) || (dr > cfg.range_gap));

    // Report of the cluster closed by a break
    r0 = '{min_angle, min_range, first_angle, first_range,
           prev_angle, prev_range, cluster_count, 1'b0};
    v0 = brk && (cluster_count >= cfg.min_points);

    prev_angle_next    = prev_angle;
    prev_range_next    = prev_range;
    first_angle_next   = first_angle;
    first_range_next   = first_range;
    min_angle_next     = min_angle;
    min_range_next     = min_range;
    cluster_count_next = cluster_count;
    open_mid           = cluster_open;

    if (kept) begin
      if (!cluster_open || brk) begin
        open_mid           = 1'b1;
        first_angle_next   = angle_in;
        first_range_next   = range_in;
        prev_angle_next    = angle_in;
        prev_range_next    = range_in;
        min_angle_next     = angle_in;
        min_range_next     = range_in;
        cluster_count_next = count_t'(1);
      end else begin
        if (cluster_count != COUNT_MAX) begin
          cluster_count_next = cluster_count + count_t'(1);
        end
        // Tie goes to the later point
        if (range_in <= min_range) begin
          min_range_next = range_in;
          min_angle_next = angle_in;
        end
        prev_angle_next = angle_in;
        prev_range_next = range_in;
      end
    end

    // End of scan closes whatever is open after this point
    r1 = '{min_angle_next, min_range_next, first_angle_next, first_range_next,
           prev_angle_next, prev_range_next, cluster_count_next, 1'b1};
    v1 = eos && open_mid && (cluster_count_next >= cfg.min_points);
    cluster_open_next = open_mid && !eos;

    push.num = 2'(v0) + 2'(v1);
    if (v0) begin
      push.rep[0]      = r0;
      push.rep[0].last = !v1;
    end else begin
      push.rep[0] = r1;
    end
    push.rep[1] = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_open <= 1'b0;
    end else if (fire) begin
      cluster_open <= cluster_open_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      prev_angle    <= prev_angle_next;
      prev_range    <= prev_range_next;
      first_angle   <= first_angle_next;
      first_range   <= first_range_next;
      min_angle     <= min_angle_next;
      min_range     <= min_range_next;
      cluster_count <= cluster_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/lsc_out_fifo.sv =====
// Four-entry result queue that takes up to two reports per cycle.
// Depends on lsc_pkg; drains one report per output transfer.
`default_nettype none

module lsc_out_fifo
  import lsc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire push_t push,
  output logic       has_room,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output report_t    rd_data
);

  report_t    mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;
  logic [1:0] wr_num;
  logic       pop;

  assign wr_num   = wr_en ? push.num : 2'd0;
  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (fill != 3'd0);
  assign has_room = (fill <= 3'd2);
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + wr_num;
      rd_ptr <= rd_ptr + 2'(pop);
      fill   <= fill + 3'(wr_num) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_num != 2'd0) begin
      mem[wr_ptr] <= push.rep[0];
    end
    if (wr_num == 2'd2) begin
      mem[wr_ptr + 2'd1] <= push.rep[1];
    end
  end

endmodule

`default_nettype wire

// ===== tb/lidar_scan_cluster_segmenter_top_tb.sv =====
// Testbench for lidar_scan_cluster_segmenter_top: drives points and register writes,
// predicts cluster reports in a small scoreboard class and checks every output transfer.
// Depends on lsc_pkg and the RTL of the segmenter.
module lidar_scan_cluster_segmenter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lsc_pkg::*;

  class cluster_scoreboard;
    angle_t     win_lo, win_hi;
    range_t     band_lo, band_hi;
    logic [8:0] step_a;
    range_t     step_r;
    count_t     min_pts;
    bit         open;
    angle_t     head_a, last_a, near_a;
    range_t     head_r, last_r, near_r;
    count_t     npts;
    report_t    due_reports[$];
    int         mismatches;

    function new();
      win_lo = -9'sd60;
      win_hi = 9'sd60;
      band_lo = 16'd3000;
      band_hi = 16'd4000;
      step_a = 9'd2;
      step_r = 16'd150;
      min_pts = 10'd4;
      open = 1'b0;
      head_a = '0;
      last_a = '0;
      near_a = '0;
      head_r = '0;
      last_r = '0;
      near_r = '0;
      npts = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_ANGLE_LOW: begin
          win_lo = d[8:0];
        end
        REG_ANGLE_HIGH: begin
          win_hi = d[8:0];
        end
        REG_RANGE_LOW: begin
          band_lo = d;
        end
        REG_RANGE_HIGH: begin
          band_hi = d;
        end
        REG_ANGLE_GAP: begin
          step_a = d[8:0];
        end
        REG_RANGE_GAP: begin
          step_r = d;
        end
        REG_MIN_POINTS: begin
          min_pts = d[9:0];
        end
        default: begin
        end
      endcase
    endfunction

    function report_t snapshot();
      report_t s;
      s.nearest_angle = near_a;
      s.nearest_range = near_r;
      s.left_angle = head_a;
      s.left_range = head_r;
      s.right_angle = last_a;
      s.right_range = last_r;
      s.count = npts;
      s.last = 1'b0;
      return s;
    endfunction

    // Note an accepted point and queue the cluster reports it raises.
    function void segment_point(angle_t a, range_t r, logic eos);
      report_t got[2];
      int n;
      int da;
      int dr;
      bit kept;
      n = 0;
      kept = a >= win_lo && a <= win_hi && r > band_lo && r < band_hi;
      if (kept && open) begin
        da = int'(a) - int'(last_a);
        dr = int'(r) - int'(last_r);
        if (da < 0) da = -da;
        if (dr < 0) dr = -dr;
        if (da > int'(step_a) || dr > int'(step_r)) begin
          // break: close the old cluster, the point opens the next one below
          if (npts >= min_pts) begin
            got[n] = snapshot();
            n = n + 1;
          end
          open = 1'b0;
        end else begin
          if (npts != COUNT_MAX) npts = npts + 10'd1;
          // a tie moves the nearest point to the later one
          if (r <= near_r) begin
            near_r = r;
            near_a = a;
          end
          last_a = a;
          last_r = r;
        end
      end
      if (kept && !open) begin
        open = 1'b1;
        head_a = a;
        head_r = r;
        last_a = a;
        last_r = r;
        near_a = a;
        near_r = r;
        npts = 10'd1;
      end
      if (eos && open) begin
        if (npts >= min_pts) begin
          got[n] = snapshot();
          n = n + 1;
        end
        open = 1'b0;
      end
      if (n > 0) got[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) due_reports = {due_reports, got[i]};
    endfunction

    function string describe(report_t x);
      return $sformatf("near %0d/%0d left %0d/%0d right %0d/%0d count %0d last %0b",
                       $signed(x.nearest_angle), x.nearest_range,
                       $signed(x.left_angle), x.left_range,
                       $signed(x.right_angle), x.right_range, x.count, x.last);
    endfunction

    function void check_report(report_t act);
      report_t want;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: report with none due: %s", $time, describe(act));
        return;
      end
      want = due_reports.pop_front();
      if (act.nearest_angle !== want.nearest_angle ||
          act.nearest_range !== want.nearest_range ||
          act.left_angle !== want.left_angle ||
          act.left_range !== want.left_range ||
          act.right_angle !== want.right_angle ||
          act.right_range !== want.right_range ||
          act.count !== want.count ||
          act.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: report mismatch", $time);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(act));
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  angle_t                angle_deg;
  range_t                range_mm;
  logic                  end_of_scan;
  logic                  out_valid;
  logic                  out_ready;
  angle_t                nearest_angle_deg;
  range_t                nearest_range_mm;
  angle_t                left_angle_deg;
  range_t                left_range_mm;
  angle_t                right_angle_deg;
  range_t                right_range_mm;
  count_t                point_count;
  logic                  last_of_run;

  cluster_scoreboard sb;
  report_t           seen;
  int                send_idle_pct;
  int                recv_stall_pct;

  lidar_scan_cluster_segmenter_top u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .angle_deg         (angle_deg),
    .range_mm          (range_mm),
    .end_of_scan       (end_of_scan),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .nearest_angle_deg (nearest_angle_deg),
    .nearest_range_mm  (nearest_range_mm),
    .left_angle_deg    (left_angle_deg),
    .left_range_mm     (left_range_mm),
    .right_angle_deg   (right_angle_deg),
    .right_range_mm    (right_range_mm),
    .point_count       (point_count),
    .last_of_run       (last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen.nearest_angle = nearest_angle_deg;
      seen.nearest_range = nearest_range_mm;
      seen.left_angle = left_angle_deg;
      seen.left_range = left_range_mm;
      seen.right_angle = right_angle_deg;
      seen.right_range = right_range_mm;
      seen.count = point_count;
      seen.last = last_of_run;
      sb.check_report(seen);
    end
  end

  function automatic void set_idle(int mode);
    case (mode)
      1: begin
        send_idle_pct = 82;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 82;
      end
      3: begin
        send_idle_pct = 31;
        recv_stall_pct = 31;
      end
      default: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_point(angle_t a, range_t r, logic eos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    angle_deg <= a;
    range_mm <= r;
    end_of_scan <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.segment_point(a, r, eos);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, CFG_DATA_W'(value));
    @(negedge clk);
  endtask

  task automatic configure(int lo, int hi, int rlo, int rhi, int ag, int rg, int mp);
    write_reg(REG_ANGLE_LOW, lo);
    write_reg(REG_ANGLE_HIGH, hi);
    write_reg(REG_RANGE_LOW, rlo);
    write_reg(REG_RANGE_HIGH, rhi);
    write_reg(REG_ANGLE_GAP, ag);
    write_reg(REG_RANGE_GAP, rg);
    write_reg(REG_MIN_POINTS, mp);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every due report, then let the pipeline go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.due_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_config();
    int lo, hi, rlo, rhi, ag, rg, mp, pick;
    pick = int'($urandom_range(0, 9));
    lo = 0 - int'($urandom_range(0, 180));
    hi = int'($urandom_range(0, 180));
    rlo = int'($urandom_range(0, 30000));
    rhi = rlo + 2 + int'($urandom_range(0, 30000));
    ag = int'($urandom_range(0, 5));
    rg = int'($urandom_range(0, 400));
    mp = int'($urandom_range(1, 6));
    case (pick)
      0: begin
        lo = -180;
        hi = 180;
      end
      1: begin
        rlo = 0;
        rhi = 65535;
      end
      2: ag = 0;
      3: ag = 360;
      4: rg = 0;
      5: rg = 65535;
      6: mp = 0;
      7: mp = 1;
      8: hi = lo;
      default: rhi = rlo + 2;
    endcase
    configure(lo, hi, rlo, rhi, ag, rg, mp);
  endtask

  // Scans of walking points inside the window and band, with breaks and noise.
  task automatic run_scans(int n_items);
    int lo_a, hi_a, lo_r, hi_r, gap_a, gap_r, a, r, len, dir, roll, sent;
    logic eos;
    lo_a = int'(sb.win_lo);
    hi_a = int'(sb.win_hi);
    lo_r = int'(sb.band_lo);
    hi_r = int'(sb.band_hi);
    gap_a = int'(sb.step_a);
    gap_r = (sb.step_r > 16'd2000) ? 2000 : int'(sb.step_r);
    sent = 0;
    while (sent < n_items) begin
      len = int'($urandom_range(1, 24));
      dir = ($urandom_range(0, 1) != 0) ? 1 : -1;
      if (lo_a <= hi_a) a = lo_a + int'($urandom_range(0, hi_a - lo_a));
      else a = int'($urandom_range(0, 511)) - 256;
      if (lo_r + 1 < hi_r) r = lo_r + 1 + int'($urandom_range(0, hi_r - lo_r - 2));
      else r = int'($urandom_range(0, 65535));
      for (int k = 0; k < len; k++) begin
        roll = int'($urandom_range(0, 99));
        eos = (k == len - 1);
        if (roll < 8) begin
          send_point(angle_t'($urandom_range(0, 511)), range_t'($urandom_range(0, 65535)),
                     eos || ($urandom_range(0, 15) == 0));
        end else begin
          if (roll < 12) begin
            a = a + dir * (gap_a + 1 + int'($urandom_range(0, 2)));
          end else if (roll < 16) begin
            r = r + dir * (int'(sb.step_r) + 1 + int'($urandom_range(0, 50)));
          end else begin
            if ($urandom_range(0, 3) == 0) a = a + dir * gap_a;
            else a = a + dir * int'($urandom_range(0, gap_a));
            r = r + int'($urandom_range(0, 2 * gap_r)) - gap_r;
          end
          if (lo_a <= hi_a) begin
            if (a > hi_a) a = hi_a;
            if (a < lo_a) a = lo_a;
          end
          if (lo_r + 1 < hi_r) begin
            if (r >= hi_r) r = hi_r - 1;
            if (r <= lo_r) r = lo_r + 1;
          end
          send_point(angle_t'(a), range_t'(r), eos);
        end
        sent = sent + 1;
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    angle_deg = '0;
    range_mm = '0;
    end_of_scan = 1'b0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset window -60..60, band 3001..3999, gaps 2 and 150, four points minimum.
    set_idle(0);
    send_point(-9'sd61, 16'd3500, 1'b0);
    send_point(-9'sd60, 16'd3001, 1'b0);
    send_point(-9'sd58, 16'd3150, 1'b0);
    send_point(-9'sd58, 16'd3001, 1'b0);
    send_point(-9'sd57, 16'd3151, 1'b0);
    send_point(-9'sd54, 16'd3151, 1'b0);
    send_point(9'sd61, 16'd3500, 1'b0);
    send_point(9'sd60, 16'd3999, 1'b0);
    send_point(9'sd59, 16'd3999, 1'b0);
    send_point(9'sd58, 16'd3900, 1'b0);
    send_point(9'sd57, 16'd3850, 1'b0);
    send_point(9'sd0, 16'd4000, 1'b1);
    send_point(9'sd0, 16'd3500, 1'b1);
    send_point(9'sd10, 16'd100, 1'b1);
    settle();

    // Widest window and band, zero gaps, every cluster reported.
    configure(-256, 255, 0, 65535, 0, 0, 0);
    set_idle(3);
    send_point(-9'sd256, 16'd1, 1'b0);
    send_point(-9'sd256, 16'd1, 1'b0);
    send_point(9'sd255, 16'd65534, 1'b1);
    send_point(-9'sd181, 16'd0, 1'b1);
    send_point(9'sd181, 16'd100, 1'b0);
    send_point(9'sd181, 16'd100, 1'b1);
    run_scans(60);
    settle();

    // Inverted window, then a band too narrow to hold any range.
    configure(10, -10, 3000, 4000, 2, 150, 1);
    set_idle(1);
    run_scans(40);
    settle();
    configure(-180, 180, 100, 101, 2, 150, 1);
    run_scans(40);
    settle();

    // One cluster long enough to saturate the count.
    configure(-180, 180, 0, 65535, 360, 65535, 1023);
    set_idle(2);
    for (int k = 0; k < 1030; k++)
      send_point(angle_t'(int'($urandom_range(0, 360)) - 180),
                 range_t'($urandom_range(1, 65534)), k == 1029);
    for (int k = 0; k < 5; k++)
      send_point(9'sd0, range_t'($urandom_range(1, 65534)), k == 4);
    settle();

    for (int b = 0; b < 16; b++) begin
      random_config();
      set_idle(b % 4);
      run_scans(16);
      settle();
    end

    if (sb.mismatches == 0 && sb.due_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
